// ===== src/atbb_pkg.sv =====
// Shared types and constants for the alpha tight bounding box block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package atbb_pkg;

  // Fixed field widths
  localparam int ALPHA_W    = 8;
  localparam int OFFSET_W   = 14;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Pixel queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_THRESHOLD = 2'd0,
    CFG_CELL_WIDTH      = 2'd1,
    CFG_CELL_HEIGHT     = 2'd2
  } cfg_reg_t;

  // One input pixel transaction
  typedef struct packed {
    logic [ALPHA_W-1:0]  pixel_alpha;
    logic [OFFSET_W-1:0] cell_x_offset;
    logic [OFFSET_W-1:0] cell_y_offset;
    logic                last_pixel;
  } pixel_item_t;

  // One result transaction
  typedef struct packed {
    logic [14:0] box_x;
    logic [14:0] box_y;
    logic [10:0] box_width;
    logic [10:0] box_height;
    logic [15:0] center_x_doubled;
    logic [15:0] center_y_doubled;
  } box_item_t;

  // Classification of one pixel, produced by the front
  typedef struct packed {
    logic                occupied;
    logic                last;
    logic [OFFSET_W-1:0] x_offset;
    logic [OFFSET_W-1:0] y_offset;
  } pixel_tag_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

endpackage

// ===== src/atbb_front.sv =====
// Front end: tracks the raster position of each pixel and classifies it.
// Depends on atbb_pkg for the pixel and tag types.
module atbb_front #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  atbb_pkg::pixel_item_t           pixel,
  input  logic [atbb_pkg::ALPHA_W-1:0]    alpha_threshold,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   side_w,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   side_h,
  output atbb_pkg::pixel_tag_t            tag,
  output logic [$clog2(MAX_SIDE)-1:0]     tag_col,
  output logic [$clog2(MAX_SIDE)-1:0]     tag_row
);

  localparam int CLW = $clog2(MAX_SIDE);
  localparam int SW  = $clog2(MAX_SIDE + 1);

  logic [CLW-1:0] column_counter;
  logic [CLW-1:0] column_counter_next;
  logic [SW-1:0]  row_counter;
  logic [SW-1:0]  row_counter_next;
  logic           in_cell;
  logic           row_end;

  // Classify the pixel at the current raster position
  assign in_cell = row_counter < side_h;
  assign row_end = (SW'(column_counter) + SW'(1)) >= side_w;

  always_comb begin
    tag.occupied = in_cell && (SW'(column_counter) < side_w) &&
                   (pixel.pixel_alpha > alpha_threshold);
    tag.last     = pixel.last_pixel;
    tag.x_offset = pixel.cell_x_offset;
    tag.y_offset = pixel.cell_y_offset;
    tag_col      = column_counter;
    tag_row      = CLW'(row_counter);
  end

  // Advance the raster position; restart on the last pixel of a cell
  always_comb begin
    column_counter_next = column_counter;
    row_counter_next    = row_counter;
    if (pixel.last_pixel) begin
      column_counter_next = '0;
      row_counter_next    = '0;
    end else if (in_cell) begin
      if (row_end) begin
        column_counter_next = '0;
        row_counter_next    = row_counter + SW'(1);
      end else begin
        column_counter_next = column_counter + CLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (push) begin
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
    end
  end

endmodule

// ===== src/atbb_queue.sv =====
// Short flip-flop queue that decouples the front from the back.
// Depends on atbb_pkg for the depth constants and the status type.
module atbb_queue #(
  parameter int WIDTH = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [WIDTH-1:0]        push_data,
  input  logic                    pop,
  output logic [WIDTH-1:0]        head_data,
  output atbb_pkg::queue_status_t status
);

  localparam int DEPTH = atbb_pkg::QUEUE_DEPTH;
  localparam int PW    = atbb_pkg::QUEUE_PTR_W;
  localparam int CW    = atbb_pkg::QUEUE_CNT_W;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign head_data    = mem[rd_ptr];
  assign status.full  = count == CW'(DEPTH);
  assign status.empty = count == '0;
  assign status.count = count;

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/atbb_back.sv =====
// Back end: folds classified pixels into the box extents and builds the result.
// Depends on atbb_pkg for the tag and result types.
module atbb_back #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  atbb_pkg::pixel_tag_t          head_tag,
  input  logic [$clog2(MAX_SIDE)-1:0]   head_col,
  input  logic [$clog2(MAX_SIDE)-1:0]   head_row,
  input  logic [$clog2(MAX_SIDE+1)-1:0] side_w,
  input  logic [$clog2(MAX_SIDE+1)-1:0] side_h,
  output logic                          pop,
  output logic                          box_valid,
  input  logic                          box_stall,
  output atbb_pkg::box_item_t           box
);

  localparam int CLW = $clog2(MAX_SIDE);
  localparam int SW  = $clog2(MAX_SIDE + 1);

  logic [CLW-1:0] min_column, min_column_next;
  logic [CLW-1:0] max_column, max_column_next;
  logic [CLW-1:0] min_row, min_row_next;
  logic [CLW-1:0] max_row, max_row_next;
  logic           any_occupied, any_occupied_next;
  logic           out_free;
  logic           hit;
  logic           finish;
  logic [CLW-1:0] left, right, top, bottom;
  logic [SW-1:0]  bw, bh;
  logic [14:0]    bx, by;
  atbb_pkg::box_item_t result;

  // Take a pixel unless it closes a cell and the result slot is busy
  assign out_free = !box_valid || !box_stall;
  assign pop      = head_valid && (!head_tag.last || out_free);
  assign hit      = pop && head_tag.occupied;
  assign finish   = pop && head_tag.last;

  // Extents including the pixel being taken
  always_comb begin
    min_column_next   = (hit && (!any_occupied || head_col < min_column)) ? head_col : min_column;
    max_column_next   = (hit && (!any_occupied || head_col > max_column)) ? head_col : max_column;
    min_row_next      = (hit && (!any_occupied || head_row < min_row)) ? head_row : min_row;
    max_row_next      = (hit && (!any_occupied || head_row > max_row)) ? head_row : max_row;
    any_occupied_next = any_occupied || hit;
  end

  // Build the box; an empty cell gives the bottom-right pixel
  always_comb begin
    if (any_occupied_next) begin
      left   = min_column_next;
      right  = max_column_next;
      top    = min_row_next;
      bottom = max_row_next;
    end else begin
      left   = CLW'(side_w - SW'(1));
      right  = CLW'(side_w - SW'(1));
      top    = CLW'(side_h - SW'(1));
      bottom = CLW'(side_h - SW'(1));
    end
    bw = SW'(right) - SW'(left) + SW'(1);
    bh = SW'(bottom) - SW'(top) + SW'(1);
    bx = 15'(head_tag.x_offset) + 15'(left);
    by = 15'(head_tag.y_offset) + 15'(top);
    result.box_x            = bx;
    result.box_y            = by;
    result.box_width        = 11'(bw);
    result.box_height       = 11'(bh);
    result.center_x_doubled = {bx, 1'b0} + 16'(bw);
    result.center_y_doubled = {by, 1'b0} + 16'(bh);
  end

  // Hold extents; clear them when a cell closes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_column   <= '1;
      max_column   <= '0;
      min_row      <= '1;
      max_row      <= '0;
      any_occupied <= 1'b0;
    end else if (finish) begin
      min_column   <= '1;
      max_column   <= '0;
      min_row      <= '1;
      max_row      <= '0;
      any_occupied <= 1'b0;
    end else begin
      min_column   <= min_column_next;
      max_column   <= max_column_next;
      min_row      <= min_row_next;
      max_row      <= max_row_next;
      any_occupied <= any_occupied_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (finish) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      box <= result;
    end
  end

endmodule

// ===== src/alpha_tight_bounding_box.sv =====
// Alpha tight bounding box: takes the alpha values of one cell in raster order,
// one pixel a cycle while pixel_stall is low, and after the pixel marked last
// gives the tight box around the pixels whose alpha exceeds the threshold, in
// sheet coordinates, with the box centre in half-pixel units. An empty cell
// gives a 1x1 box at its bottom-right pixel; pixels beyond width times height
// are ignored. A pixel is classified combinationally against the position
// counter as it is accepted, and waits in a four-entry queue before the extent
// unit folds it in; the result register loads on the cycle the last pixel
// leaves the queue, so a box appears in the cycle after that. Input stall rises
// only when the queue is full, which happens when results are held back at the
// output. The user must write the configuration registers through the cfg port
// (always ready) only while no cell is in flight; the block does not enforce it.
// Depends on atbb_pkg, atbb_front, atbb_queue and atbb_back.
module alpha_tight_bounding_box #(
  parameter int MAX_SIDE = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  atbb_pkg::pixel_item_t            pixel,
  output logic                             box_valid,
  input  logic                             box_stall,
  output atbb_pkg::box_item_t              box,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [atbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atbb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CLW  = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = (SW > atbb_pkg::CFG_DATA_W) ? SW : atbb_pkg::CFG_DATA_W;
  localparam int TAGW = $bits(atbb_pkg::pixel_tag_t);
  localparam int QW   = TAGW + 2 * CLW;

  logic [atbb_pkg::ALPHA_W-1:0]    alpha_threshold;
  logic [atbb_pkg::CFG_DATA_W-1:0] cell_width;
  logic [atbb_pkg::CFG_DATA_W-1:0] cell_height;
  logic [CW-1:0]                   width_ext, height_ext;
  logic [SW-1:0]                   side_w, side_h;

  atbb_pkg::pixel_tag_t    front_tag, head_tag;
  logic [CLW-1:0]          front_col, front_row, head_col, head_row;
  logic [QW-1:0]           head_data;
  atbb_pkg::queue_status_t q_stat;
  logic                    q_push, q_pop;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_threshold <= '0;
      cell_width      <= atbb_pkg::CFG_DATA_W'(16);
      cell_height     <= atbb_pkg::CFG_DATA_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        atbb_pkg::CFG_ALPHA_THRESHOLD: alpha_threshold <= cfg_data[atbb_pkg::ALPHA_W-1:0];
        atbb_pkg::CFG_CELL_WIDTH:      cell_width      <= cfg_data;
        atbb_pkg::CFG_CELL_HEIGHT:     cell_height     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp cell sides into 1..MAX_SIDE
  assign width_ext  = CW'(cell_width);
  assign height_ext = CW'(cell_height);
  assign side_w = (width_ext == '0) ? SW'(1) :
                  (width_ext > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(width_ext);
  assign side_h = (height_ext == '0) ? SW'(1) :
                  (height_ext > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(height_ext);

  // Accept pixels while the queue has room
  assign pixel_stall = q_stat.full;
  assign q_push      = pixel_valid && !pixel_stall;

  atbb_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (q_push),
    .pixel           (pixel),
    .alpha_threshold (alpha_threshold),
    .side_w          (side_w),
    .side_h          (side_h),
    .tag             (front_tag),
    .tag_col         (front_col),
    .tag_row         (front_row)
  );

  atbb_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({front_row, front_col, front_tag}),
    .pop       (q_pop),
    .head_data (head_data),
    .status    (q_stat)
  );

  assign head_tag = head_data[TAGW-1:0];
  assign head_col = head_data[TAGW +: CLW];
  assign head_row = head_data[TAGW + CLW +: CLW];

  atbb_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (!q_stat.empty),
    .head_tag   (head_tag),
    .head_col   (head_col),
    .head_row   (head_row),
    .side_w     (side_w),
    .side_h     (side_h),
    .pop        (q_pop),
    .box_valid  (box_valid),
    .box_stall  (box_stall),
    .box        (box)
  );

  // A pending result is never overwritten by the close of the next cell
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && head_tag.last && box_valid && box_stall) |-> !q_pop)
    else $error("cell closed while result was held");

  // Queue occupancy follows push without pop
  a_queue_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(q_push && !q_pop)) |-> (q_stat.count == $past(q_stat.count) + 1))
    else $error("queue count lost a push");

  // Closing a cell always presents a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && head_tag.last && q_pop) |=> box_valid)
    else $error("cell closed without a result");

endmodule

// ===== tb/atbb_box_checker.sv =====
// Checker for the alpha tight bounding box: watches the pixel, box and cfg channels,
// predicts each box from the accepted pixels and compares it field by field.
// Depends on atbb_pkg for the transaction types and register indexes.
module atbb_box_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  input  logic                             pixel_stall,
  input  atbb_pkg::pixel_item_t            pixel,
  input  logic                             box_valid,
  input  logic                             box_stall,
  input  atbb_pkg::box_item_t              box,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [atbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [atbb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               error_count,
  output int                               pending_count,
  output int                               box_count
);

  localparam int MAX_SIDE = 1024;

  // Shadow copy of the registers and of the extent tracker
  logic [7:0]  threshold_q;
  logic [10:0] width_q;
  logic [10:0] height_q;
  logic [9:0]  col_q;
  logic [10:0] row_q;
  logic [9:0]  min_col_q;
  logic [9:0]  max_col_q;
  logic [9:0]  min_row_q;
  logic [9:0]  max_row_q;
  logic        seen_q;

  atbb_pkg::box_item_t expected_boxes[$];

  function automatic logic [10:0] clamp_side(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > MAX_SIDE) return 11'(MAX_SIDE);
    return v;
  endfunction

  task automatic clear_cell();
    col_q = '0;
    row_q = '0;
    min_col_q = '1;
    max_col_q = '0;
    min_row_q = '1;
    max_row_q = '0;
    seen_q = 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: box field %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : track
    logic [10:0] w;
    logic [10:0] h;
    logic [9:0]  left;
    logic [9:0]  right;
    logic [9:0]  top;
    logic [9:0]  bottom;
    logic [10:0] bw;
    logic [10:0] bh;
    logic [14:0] bx;
    logic [14:0] by;
    atbb_pkg::box_item_t want;

    if (rst) begin
      threshold_q = '0;
      width_q = 11'd16;
      height_q = 11'd16;
      clear_cell();
      expected_boxes.delete();
      error_count = 0;
      box_count = 0;
    end else begin
      // Fold an accepted pixel transaction into the extent
      if (pixel_valid && !pixel_stall) begin
        w = clamp_side(width_q);
        h = clamp_side(height_q);
        if (row_q < h) begin
          if ({1'b0, col_q} < w && pixel.pixel_alpha > threshold_q) begin
            if (!seen_q || col_q < min_col_q) min_col_q = col_q;
            if (!seen_q || col_q > max_col_q) max_col_q = col_q;
            if (!seen_q || row_q[9:0] < min_row_q) min_row_q = row_q[9:0];
            if (!seen_q || row_q[9:0] > max_row_q) max_row_q = row_q[9:0];
            seen_q = 1'b1;
          end
          if ({1'b0, col_q} + 11'd1 >= w) begin
            col_q = '0;
            row_q = row_q + 11'd1;
          end else begin
            col_q = col_q + 10'd1;
          end
        end
        // Close the cell: empty cells fall back to the bottom-right pixel
        if (pixel.last_pixel) begin
          if (seen_q) begin
            left = min_col_q;
            right = max_col_q;
            top = min_row_q;
            bottom = max_row_q;
          end else begin
            left = 10'(w - 11'd1);
            right = left;
            top = 10'(h - 11'd1);
            bottom = top;
          end
          bw = 11'(right - left) + 11'd1;
          bh = 11'(bottom - top) + 11'd1;
          bx = 15'(pixel.cell_x_offset) + 15'(left);
          by = 15'(pixel.cell_y_offset) + 15'(top);
          want.box_x = bx;
          want.box_y = by;
          want.box_width = bw;
          want.box_height = bh;
          want.center_x_doubled = 16'(bx) * 16'd2 + 16'(bw);
          want.center_y_doubled = 16'(by) * 16'd2 + 16'(bh);
          expected_boxes.push_back(want);
          clear_cell();
        end
      end

      // Compare an accepted box transaction with the oldest prediction
      if (box_valid && !box_stall) begin
        box_count++;
        if (expected_boxes.size() == 0) begin
          $display("%0t: box with nothing expected, expected none, actual %h", $time, box);
          error_count++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("box_x", int'(want.box_x), int'(box.box_x));
          check_field("box_y", int'(want.box_y), int'(box.box_y));
          check_field("box_width", int'(want.box_width), int'(box.box_width));
          check_field("box_height", int'(want.box_height), int'(box.box_height));
          check_field("center_x_doubled", int'(want.center_x_doubled),
                      int'(box.center_x_doubled));
          check_field("center_y_doubled", int'(want.center_y_doubled),
                      int'(box.center_y_doubled));
        end
      end

      // Track register writes; they apply from the next pixel on
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          atbb_pkg::CFG_ALPHA_THRESHOLD: threshold_q = cfg_data[7:0];
          atbb_pkg::CFG_CELL_WIDTH:      width_q = cfg_data;
          atbb_pkg::CFG_CELL_HEIGHT:     height_q = cfg_data;
          default: ;
        endcase
      end
    end
    pending_count = expected_boxes.size();
  end

endmodule

// ===== tb/tb_alpha_tight_bounding_box.sv =====
// Top of the alpha tight bounding box testbench: clock, reset, pixel and cfg stimulus,
// random output stall, watchdog and verdict.
// Depends on atbb_pkg, the block alpha_tight_bounding_box and atbb_box_checker.
module tb_alpha_tight_bounding_box;

  localparam int IDX_W  = atbb_pkg::CFG_IDX_W;
  localparam int DATA_W = atbb_pkg::CFG_DATA_W;
  localparam int OFF_W  = atbb_pkg::OFFSET_W;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;  // index with no register behind it
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int MAX_SIDE       = 1024;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  pixel_valid;
  logic                  pixel_stall;
  atbb_pkg::pixel_item_t pixel;
  logic                  box_valid;
  logic                  box_stall = 1'b0;
  atbb_pkg::box_item_t   box;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index;
  logic [DATA_W-1:0]     cfg_data;

  int error_count;
  int pending_count;
  int box_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pixel_count = 0;
  int cell_count = 0;
  int setting_count = 0;
  int quiet_cycles = 0;

  // Effective settings, used only to shape the stimulus
  logic [7:0] thr_eff;
  int         side_w;
  int         side_h;

  alpha_tight_bounding_box #(.MAX_SIDE(MAX_SIDE)) u_dut (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  atbb_box_checker u_checker (
    .clk(clk), .rst(rst),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
    .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(error_count), .pending_count(pending_count), .box_count(box_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the box channel at random
  always @(negedge clk) begin
    box_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (box_valid && !box_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d boxes still pending", $time, pending_count);
        $display("tb_alpha_tight_bounding_box failed");
        $finish;
      end
    end
  end

  function automatic int eff_side(input logic [DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] pick_side();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 11'd0;
          1: return 11'd1;
          2: return 11'd1024;
          default: return '1;
        endcase
      end
      1: return DATA_W'($urandom_range(2047));
      default: return DATA_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return OFF_W'($urandom_range((1 << OFF_W) - 1));
    endcase
  endfunction

  // Present one pixel transaction and hold it until accepted; call at a falling edge
  task automatic send_pixel(input logic [7:0] alpha, input logic [OFF_W-1:0] xo,
                            input logic [OFF_W-1:0] yo, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= '{pixel_alpha: alpha, cell_x_offset: xo, cell_y_offset: yo, last_pixel: last};
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
    pixel_count++;
  endtask

  // Leave cfg_valid high so that back-to-back writes never toggle it
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [DATA_W-1:0] thr_data,
                              input logic [DATA_W-1:0] w_data,
                              input logic [DATA_W-1:0] h_data, input bit poke_unused);
    if (poke_unused) write_reg(CFG_UNUSED, DATA_W'($urandom_range(2047)));
    write_reg(atbb_pkg::CFG_ALPHA_THRESHOLD, thr_data);
    write_reg(atbb_pkg::CFG_CELL_WIDTH, w_data);
    write_reg(atbb_pkg::CFG_CELL_HEIGHT, h_data);
    cfg_valid <= 1'b0;
    thr_eff = thr_data[7:0];
    side_w = eff_side(w_data);
    side_h = eff_side(h_data);
    setting_count++;
  endtask

  // Drop valid, wait out every pending box and the pipeline behind it
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int random_sent;
    int budget;
    int phase_sent;
    int area;
    int len;
    int dens;
    int pick;
    logic [7:0] alpha;
    logic [DATA_W-1:0] thr_data;

    rst <= 1'b1;
    pixel_valid <= 1'b0;
    pixel <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= atbb_pkg::CFG_ALPHA_THRESHOLD;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 50;

    // Directed: 2x2 cells, alpha 0 sits at the threshold and stays empty
    apply_config(11'd0, 11'd2, 11'd2, 1'b0);
    send_pixel(8'd1, '0, '0, 1'b0);
    send_pixel(8'd0, '0, '0, 1'b0);
    send_pixel(8'd0, '0, '0, 1'b0);
    send_pixel(8'd255, '0, '0, 1'b1);
    // Empty cell at the far sheet corner
    repeat (3) send_pixel(8'd0, '1, '1, 1'b0);
    send_pixel(8'd0, '1, '1, 1'b1);
    // Short cell
    send_pixel(8'd0, 14'd5, 14'd9, 1'b0);
    send_pixel(8'd255, 14'd100, 14'd200, 1'b1);
    // Extra pixels past the cell are dropped
    repeat (4) send_pixel(8'd0, '0, '0, 1'b0);
    repeat (2) send_pixel(8'd255, '1, '0, 1'b0);
    send_pixel(8'd255, 14'd7, 14'd3, 1'b1);
    wait_idle();

    // Directed: oversize sides clamp, threshold 255 leaves everything empty
    apply_config(11'd255, '1, '1, 1'b1);
    send_pixel(8'd255, '1, '1, 1'b1);
    wait_idle();

    // Directed: zero width counts as one column
    apply_config(11'd254, 11'd0, 11'd1024, 1'b0);
    send_pixel(8'd255, '0, '0, 1'b0);
    send_pixel(8'd254, '0, '0, 1'b0);
    send_pixel(8'd255, 14'd8191, 14'd1, 1'b1);
    wait_idle();

    // Random phases, each under a fresh register setting
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 50;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(7))
        0: thr_data = 11'd0;
        1: thr_data = ($urandom_range(1)) ? 11'd255 : '1;
        default: thr_data = DATA_W'($urandom_range(2047));
      endcase
      apply_config(thr_data, pick_side(), pick_side(), $urandom_range(3) == 0);

      budget = $urandom_range(90, 30);
      phase_sent = 0;
      while (phase_sent < budget && random_sent < RANDOM_ITEMS) begin
        // Small cells are mostly complete, some end early or run long; larger ones end early
        area = side_w * side_h;
        if (area > 64) begin
          len = $urandom_range(48, 1);
        end else begin
          pick = $urandom_range(9);
          if (pick < 8) len = area;
          else if (pick == 8) len = $urandom_range(area, 1);
          else len = area + $urandom_range(6, 1);
        end
        case ($urandom_range(3))
          0: dens = 0;
          1: dens = $urandom_range(10, 1);
          2: dens = $urandom_range(60, 10);
          default: dens = 100;
        endcase
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8) alpha = 8'($urandom_range(255));
          else if ($urandom_range(99) < dens && thr_eff != 8'hFF)
            alpha = 8'($urandom_range(255, int'(thr_eff) + 1));
          else alpha = 8'($urandom_range(int'(thr_eff), 0));
          send_pixel(alpha, pick_offset(), pick_offset(), i == len - 1);
        end
        cell_count++;
        phase_sent += len;
        random_sent += len;
      end
      wait_idle();
    end

    $display("Run covered %0d pixels in %0d random cells over %0d register settings.",
             pixel_count, cell_count, setting_count);
    $display("Compared %0d boxes; %0d mismatches.", box_count, error_count);
    if (error_count == 0) begin
      $display("tb_alpha_tight_bounding_box passed");
    end else begin
      $display("tb_alpha_tight_bounding_box failed");
    end
    $finish;
  end

endmodule
